// ===== rtl/core/tddl_pkg.sv =====
// ----------------------------------------------------------------------------
// tddl_pkg: shared types and constants for the trace driven delay link
// Transaction structs, request and result codes, queue sizing and the
// constants for the millisecond to one-second bin conversion.
// ----------------------------------------------------------------------------
package tddl_pkg;

    localparam int unsigned QUEUE_DEPTH = 256;
    localparam int unsigned TAG_WIDTH   = 16;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned ENTRY_W     = TAG_WIDTH + 32;

    localparam logic [15:0] DELAY_RESET = 16'd20;

    // now / 1000 = (now >> 3) / 125, done as a multiply by a rounded-up reciprocal
    localparam int unsigned BIN_PRE_SHIFT = 3;
    localparam int unsigned BIN_SHIFT     = 36;
    localparam logic [29:0] BIN_RECIP     = 30'd549755814;
    localparam int unsigned PROD_W        = 59;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_PACKET      = 2'd0,
        REQ_OPPORTUNITY = 2'd1,
        REQ_TICK        = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_REPORT  = 2'd1,
        KIND_DROP    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [15:0] packet_tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [15:0] out_tag;
        logic [31:0] queue_delay;
        logic [22:0] bin_index;
        logic [31:0] used_count;
        logic [31:0] total_count;
        logic [7:0]  skipped_bins;
        logic        last;
    } out_item_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        if (v == CNT_MAX)
            return v;
        else
            return v + 32'd1;
    endfunction

endpackage

// ===== rtl/core/tddl_ram.sv =====
// ----------------------------------------------------------------------------
// tddl_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tddl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/trace_driven_delay_link.sv =====
// ----------------------------------------------------------------------------
// trace_driven_delay_link: fixed delay link emulator with trace opportunities
// Packets queue with their entry time; opportunities release the head packet
// once its delay has elapsed. Per-second opportunity statistics are reported.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry request transactions (packet, opportunity,
//   tick). out_valid/out_ready/out_data carry result transactions (delivery,
//   bin report, drop); last marks the final result of one request.
//   cfg_we/cfg_wdata write delay_ms; write only while the block is idle.
// Timing: a request is registered on acceptance and its first result is
//   presented once it issues into the output register.
// Throughput: one request per cycle while the output is not stalled. A request
//   that closes a bin and also delivers or drops gives two results and holds the
//   input while the second one drains. The head of the queue is read from RAM
//   every cycle at the next head address, so back-to-back pops need no bubble.
// Reset: queue empty, counters and current bin zero, delay_ms = 20. The queue
//   RAM is not cleared; only occupied entries are read.
// Stall: while out_ready is low the result is held, at most one more result is
//   buffered, and in_ready drops once the pipeline is full.
// ----------------------------------------------------------------------------
module trace_driven_delay_link (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  tddl_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tddl_pkg::out_item_t out_data
);

    localparam int unsigned PTR_W = tddl_pkg::PTR_W;
    localparam int unsigned CNT_W = tddl_pkg::CNT_W;
    localparam int unsigned TW    = tddl_pkg::TAG_WIDTH;

    logic [15:0]                      delay_reg;
    logic                             s1_valid_reg;
    tddl_pkg::in_item_t               s1_item_reg;
    logic [tddl_pkg::PROD_W-1:0]      s1_prod_reg;
    logic [PTR_W-1:0]                 head_reg, head_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [31:0]                      used_reg, used_next;
    logic [31:0]                      total_reg, total_next;
    logic [22:0]                      bin_reg, bin_next;
    logic                             out_valid_reg, out_valid_next;
    tddl_pkg::out_item_t              out_reg, out_next;
    logic                             pend_valid_reg, pend_valid_next;
    tddl_pkg::out_item_t              pend_reg, pend_next;
    logic                             byp_valid_reg;
    logic [tddl_pkg::ENTRY_W-1:0]     byp_reg;

    logic                             can_issue, issue;
    logic [28:0]                      now_pre;
    logic [22:0]                      now_bin, gap;
    logic                             closing, full, push, pop;
    logic [PTR_W:0]                   tail_sum;
    logic [PTR_W-1:0]                 tail;
    logic [tddl_pkg::ENTRY_W-1:0]     wr_entry, ram_q, head_entry;
    logic [TW-1:0]                    head_tag;
    logic [31:0]                      head_time;
    logic [32:0]                      release_sum;
    logic [31:0]                      used_base, total_base;
    tddl_pkg::out_item_t              report, evt;
    logic                             has_evt;

    assign now_pre   = in_data.now_ms[31:tddl_pkg::BIN_PRE_SHIFT];
    assign can_issue = !pend_valid_reg && (!out_valid_reg || out_ready);
    assign issue     = s1_valid_reg && can_issue;
    assign in_ready  = !s1_valid_reg || issue;

    assign now_bin = s1_prod_reg[tddl_pkg::PROD_W-1:tddl_pkg::BIN_SHIFT];
    assign closing = now_bin > bin_reg;
    assign gap     = now_bin - bin_reg - 23'd1;
    assign full    = count_reg == CNT_W'(tddl_pkg::QUEUE_DEPTH);

    assign head_entry  = byp_valid_reg ? byp_reg : ram_q;
    assign head_tag    = head_entry[tddl_pkg::ENTRY_W-1:32];
    assign head_time   = head_entry[31:0];
    assign release_sum = {1'b0, head_time} + {17'd0, delay_reg};

    assign push = issue && (s1_item_reg.req_type == tddl_pkg::REQ_PACKET) && !full;
    assign pop  = issue && (s1_item_reg.req_type == tddl_pkg::REQ_OPPORTUNITY)
                  && (count_reg != '0) && (release_sum <= {1'b0, s1_item_reg.now_ms});

    assign tail_sum = {1'b0, head_reg} + (PTR_W+1)'(count_reg);
    assign tail     = (tail_sum >= (PTR_W+1)'(tddl_pkg::QUEUE_DEPTH))
                      ? PTR_W'(tail_sum - (PTR_W+1)'(tddl_pkg::QUEUE_DEPTH))
                      : tail_sum[PTR_W-1:0];
    assign wr_entry = {TW'(s1_item_reg.packet_tag), s1_item_reg.now_ms};

    assign head_next = pop ? tddl_pkg::ptr_inc(head_reg) : head_reg;

    tddl_ram #(
        .WIDTH (tddl_pkg::ENTRY_W),
        .DEPTH (tddl_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail),
        .wdata (wr_entry),
        .raddr (head_next),
        .rdata (ram_q)
    );

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;

        used_base  = closing ? 32'd0 : used_reg;
        total_base = closing ? 32'd0 : total_reg;
        used_next  = used_reg;
        total_next = total_reg;
        bin_next   = bin_reg;
        if (issue)
        begin
            used_next  = pop ? tddl_pkg::sat_inc(used_base) : used_base;
            total_next = (s1_item_reg.req_type == tddl_pkg::REQ_OPPORTUNITY)
                         ? tddl_pkg::sat_inc(total_base) : total_base;
            if (closing)
                bin_next = now_bin;
        end

        report              = '0;
        report.out_kind     = tddl_pkg::KIND_REPORT;
        report.bin_index    = bin_reg;
        report.used_count   = used_reg;
        report.total_count  = total_reg;
        report.skipped_bins = (gap > 23'd255) ? 8'd255 : gap[7:0];
        report.last         = 1'b0;

        evt     = '0;
        has_evt = 1'b0;
        case (s1_item_reg.req_type)
            tddl_pkg::REQ_PACKET:
            begin
                has_evt      = full;
                evt.out_kind = tddl_pkg::KIND_DROP;
                evt.out_tag  = 16'(TW'(s1_item_reg.packet_tag));
            end
            tddl_pkg::REQ_OPPORTUNITY:
            begin
                has_evt         = pop;
                evt.out_kind    = tddl_pkg::KIND_DELIVER;
                evt.out_tag     = 16'(head_tag);
                evt.queue_delay = s1_item_reg.now_ms - head_time;
            end
            default:
            begin
                has_evt = 1'b0;
            end
        endcase
        evt.last = 1'b1;

        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (issue)
        begin
            out_valid_next  = closing || has_evt;
            pend_valid_next = closing && has_evt;
            pend_next       = evt;
            if (closing)
            begin
                out_next      = report;
                out_next.last = !has_evt;
            end
            else
            begin
                out_next = evt;
            end
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next  = pend_valid_reg;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg      <= tddl_pkg::DELAY_RESET;
            s1_valid_reg   <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            used_reg       <= '0;
            total_reg      <= '0;
            bin_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            byp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                delay_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            head_reg       <= head_next;
            count_reg      <= count_next;
            used_reg       <= used_next;
            total_reg      <= total_next;
            bin_reg        <= bin_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            byp_valid_reg  <= push && (tail == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
            s1_prod_reg <= {30'd0, now_pre} * {29'd0, tddl_pkg::BIN_RECIP};
        end
        out_reg  <= out_next;
        pend_reg <= pend_next;
        byp_reg  <= wr_entry;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
